/* hw/rtl/hlfd_pkg.sv */
`default_nettype none

package hlfd_pkg;

  localparam int PADDR_W = 5;

  localparam logic [2:0] REG_HEADER_BYTES   = 3'd0;
  localparam logic [2:0] REG_HEADER_VALUE   = 3'd1;
  localparam logic [2:0] REG_LENGTH_BYTES   = 3'd2;
  localparam logic [2:0] REG_CHECKSUM_BYTES = 3'd3;
  localparam logic [2:0] REG_MAX_FRAME      = 3'd4;

  localparam logic [16:0] MAX_FRAME_CAP = 17'd65536;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2,
    PH_CSUM = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_REJECT  = 2'd2
  } kind_t;

  // effective (clamped) settings
  typedef struct packed {
    logic [2:0]  header_bytes;
    logic [31:0] header_value;
    logic [2:0]  length_bytes;
    logic [2:0]  checksum_bytes;
    logic [16:0] limit;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [15:0] byte_index;
    logic [31:0] frame_length;
    logic [31:0] received_checksum;
  } res_t;

  function automatic logic [2:0] clamp14(input logic [2:0] v);
    logic [2:0] r;
    begin
      r = v;
      if (v == 3'd0) r = 3'd1;
      else if (v > 3'd4) r = 3'd4;
      return r;
    end
  endfunction

  // bytes arrive little-endian; new byte lands at the top of an n-byte field
  function automatic logic [31:0] shift_in(input logic [31:0] acc, input logic [7:0] b,
                                           input logic [2:0] n);
    logic [31:0] r;
    begin
      r = acc >> 8;
      case (n)
        3'd1:    r = r | {24'd0, b};
        3'd2:    r = r | {16'd0, b, 8'd0};
        3'd3:    r = r | {8'd0, b, 16'd0};
        default: r = r | {b, 24'd0};
      endcase
      return r;
    end
  endfunction

  function automatic logic [31:0] hdr_mask(input logic [2:0] n);
    logic [31:0] r;
    begin
      case (n)
        3'd1:    r = 32'h0000_00FF;
        3'd2:    r = 32'h0000_FFFF;
        3'd3:    r = 32'h00FF_FFFF;
        default: r = 32'hFFFF_FFFF;
      endcase
      return r;
    end
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/hlfd_in_if.sv */
`default_nettype none

interface hlfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

/* hw/rtl/hlfd_out_if.sv */
`default_nettype none

interface hlfd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  payload_byte;
  logic [15:0] byte_index;
  logic [31:0] frame_length;
  logic [31:0] received_checksum;

  modport source (output valid, output kind, output payload_byte, output byte_index,
                  output frame_length, output received_checksum, input ready);
  modport sink (input valid, input kind, input payload_byte, input byte_index,
                input frame_length, input received_checksum, output ready);
endinterface

`default_nettype wire

/* hw/rtl/hlfd_cfg_regs.sv */
`default_nettype none

module hlfd_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [hlfd_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output hlfd_pkg::cfg_t                   cfg
);
  import hlfd_pkg::*;

  logic [2:0]  header_bytes;
  logic [31:0] header_value;
  logic [2:0]  length_bytes;
  logic [2:0]  checksum_bytes;
  logic [16:0] max_frame;
  logic [2:0]  reg_idx;
  logic        wr;

  assign reg_idx = paddr[4:2];
  assign wr      = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_bytes   <= 3'd2;
      header_value   <= 32'd0;
      length_bytes   <= 3'd2;
      checksum_bytes <= 3'd0;
      max_frame      <= 17'd256;
    end else if (wr) begin
      case (reg_idx)
        REG_HEADER_BYTES:   header_bytes   <= pwdata[2:0];
        REG_HEADER_VALUE:   header_value   <= pwdata;
        REG_LENGTH_BYTES:   length_bytes   <= pwdata[2:0];
        REG_CHECKSUM_BYTES: checksum_bytes <= pwdata[2:0];
        REG_MAX_FRAME:      max_frame      <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_HEADER_BYTES:   prdata = {29'd0, header_bytes};
      REG_HEADER_VALUE:   prdata = header_value;
      REG_LENGTH_BYTES:   prdata = {29'd0, length_bytes};
      REG_CHECKSUM_BYTES: prdata = {29'd0, checksum_bytes};
      REG_MAX_FRAME:      prdata = {15'd0, max_frame};
      default:            prdata = 32'd0;
    endcase
  end

  always_comb begin
    cfg.header_bytes   = clamp14(header_bytes);
    cfg.header_value   = header_value;
    cfg.length_bytes   = clamp14(length_bytes);
    cfg.checksum_bytes = (checksum_bytes > 3'd4) ? 3'd4 : checksum_bytes;
    cfg.limit          = (max_frame > MAX_FRAME_CAP) ? MAX_FRAME_CAP : max_frame;
  end

endmodule

`default_nettype wire

/* hw/rtl/hlfd_frame_fsm.sv */
`default_nettype none

module hlfd_frame_fsm (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire hlfd_pkg::cfg_t cfg,
  input  wire logic           take,
  input  wire logic [7:0]     rx_byte,
  output hlfd_pkg::res_t      res
);
  import hlfd_pkg::*;

  phase_t      phase, phase_next;
  logic [31:0] header_window, header_window_next;
  logic [31:0] length_accum, length_accum_next;
  logic [15:0] byte_count, byte_count_next;
  logic [31:0] checksum_accum, checksum_accum_next;

  logic [31:0] win_sh, len_sh, cs_sh;
  logic [15:0] bc_inc;
  logic [2:0]  cs_n;
  logic        hdr_hit, len_more, len_reject, data_more, cs_more;

  assign cs_n       = (cfg.checksum_bytes == 3'd0) ? 3'd1 : cfg.checksum_bytes;
  assign win_sh     = shift_in(header_window, rx_byte, cfg.header_bytes);
  assign len_sh     = shift_in(length_accum, rx_byte, cfg.length_bytes);
  assign cs_sh      = shift_in(checksum_accum, rx_byte, cs_n);
  assign bc_inc     = byte_count + 16'd1;
  assign hdr_hit    = ((win_sh ^ cfg.header_value) & hdr_mask(cfg.header_bytes)) == 32'd0;
  assign len_more   = bc_inc < {13'd0, cfg.length_bytes};
  assign len_reject = ({1'b0, len_sh} + {30'd0, cfg.checksum_bytes}) >= {16'd0, cfg.limit};
  assign data_more  = {16'd0, bc_inc} < length_accum;
  assign cs_more    = bc_inc < {13'd0, cs_n};

  always_comb begin
    phase_next          = phase;
    header_window_next  = header_window;
    length_accum_next   = length_accum;
    byte_count_next     = byte_count;
    checksum_accum_next = checksum_accum;
    case (phase)
      PH_HUNT: begin
        header_window_next = win_sh;
        if (hdr_hit) begin
          phase_next        = PH_LEN;
          length_accum_next = 32'd0;
          byte_count_next   = 16'd0;
        end
      end
      PH_LEN: begin
        length_accum_next = len_sh;
        byte_count_next   = bc_inc;
        if (!len_more) begin
          byte_count_next = 16'd0;
          if (len_reject) begin
            phase_next = PH_HUNT;
          end else if (len_sh != 32'd0) begin
            phase_next = PH_DATA;
          end else if (cfg.checksum_bytes != 3'd0) begin
            checksum_accum_next = 32'd0;
            phase_next          = PH_CSUM;
          end else begin
            phase_next = PH_HUNT;
          end
        end
      end
      PH_DATA: begin
        byte_count_next = bc_inc;
        if (!data_more) begin
          byte_count_next = 16'd0;
          if (cfg.checksum_bytes != 3'd0) begin
            checksum_accum_next = 32'd0;
            phase_next          = PH_CSUM;
          end else begin
            phase_next = PH_HUNT;
          end
        end
      end
      PH_CSUM: begin
        checksum_accum_next = cs_sh;
        byte_count_next     = bc_inc;
        if (!cs_more) begin
          byte_count_next = 16'd0;
          phase_next      = PH_HUNT;
        end
      end
      default: phase_next = PH_HUNT;
    endcase
  end

  always_comb begin
    res = '0;
    case (phase)
      PH_LEN: begin
        if (!len_more) begin
          if (len_reject) begin
            res.valid        = 1'b1;
            res.kind         = KIND_REJECT;
            res.frame_length = len_sh;
          end else if (len_sh == 32'd0 && cfg.checksum_bytes == 3'd0) begin
            res.valid = 1'b1;
            res.kind  = KIND_DONE;
          end
        end
      end
      PH_DATA: begin
        res.valid        = 1'b1;
        res.payload_byte = rx_byte;
        res.byte_index   = byte_count;
        res.frame_length = length_accum;
        res.kind         = (!data_more && cfg.checksum_bytes == 3'd0) ? KIND_DONE : KIND_PAYLOAD;
      end
      PH_CSUM: begin
        if (!cs_more) begin
          res.valid             = 1'b1;
          res.kind              = KIND_DONE;
          res.frame_length      = length_accum;
          res.received_checksum = cs_sh;
        end
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      header_window  <= 32'd0;
      length_accum   <= 32'd0;
      byte_count     <= 16'd0;
      checksum_accum <= 32'd0;
    end else if (take) begin
      phase          <= phase_next;
      header_window  <= header_window_next;
      length_accum   <= length_accum_next;
      byte_count     <= byte_count_next;
      checksum_accum <= checksum_accum_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/hlfd_out_reg.sv */
`default_nettype none

module hlfd_out_reg (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           take,
  input  wire hlfd_pkg::res_t res,
  output logic                room,
  hlfd_out_if.source          dout
);
  import hlfd_pkg::*;

  logic        valid;
  kind_t       kind;
  logic [7:0]  payload_byte;
  logic [15:0] byte_index;
  logic [31:0] frame_length;
  logic [31:0] received_checksum;

  assign room = !valid || dout.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= res.valid;
    end else if (dout.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res.valid) begin
      kind              <= res.kind;
      payload_byte      <= res.payload_byte;
      byte_index        <= res.byte_index;
      frame_length      <= res.frame_length;
      received_checksum <= res.received_checksum;
    end
  end

  assign dout.valid             = valid;
  assign dout.kind              = kind;
  assign dout.payload_byte      = payload_byte;
  assign dout.byte_index        = byte_index;
  assign dout.frame_length      = frame_length;
  assign dout.received_checksum = received_checksum;

endmodule

`default_nettype wire

/* hw/rtl/header_length_frame_deframer_core.sv */
`default_nettype none

// Channel  Dir  Fields                                              Transfer
// din      in   rx_byte                                             valid && ready
// dout     out  kind, payload_byte, byte_index, frame_length,       valid && ready
//               received_checksum
// apb      in   psel/penable/pwrite/paddr/pwdata -> prdata, pready  psel && penable && pready
//
// One byte per cycle while din.ready is high: each transfer on din updates the frame
// state and, when it yields a result, loads the output register on the same edge.
// din.ready drops only while a result sits in the output register and dout.ready is low.
// Synchronous reset returns to header hunt, restores default settings and clears dout.valid.
module header_length_frame_deframer_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  hlfd_in_if.sink                          din,
  hlfd_out_if.source                       dout,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [hlfd_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import hlfd_pkg::*;

  cfg_t cfg;
  res_t res;
  logic room;
  logic take;

  assign din.ready = room;
  assign take      = din.valid && room;

  hlfd_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hlfd_frame_fsm u_fsm (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .take    (take),
    .rx_byte (din.rx_byte),
    .res     (res)
  );

  hlfd_out_reg u_out (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .res  (res),
    .room (room),
    .dout (dout)
  );

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && !dout.ready) |-> !din.ready)
    else $error("input taken while result stalled");

  a_reject_fields: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && dout.kind == KIND_REJECT) |->
      (dout.payload_byte == 8'd0 && dout.byte_index == 16'd0 &&
       dout.received_checksum == 32'd0))
    else $error("reject carries stray fields");

  a_payload_index: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && dout.kind == KIND_PAYLOAD) |->
      ({16'd0, dout.byte_index} < dout.frame_length && dout.received_checksum == 32'd0))
    else $error("payload index out of frame");

  a_result_follows_take: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && !$past(dout.valid)) |-> $past(take))
    else $error("result appeared without a transfer");

endmodule

`default_nettype wire

/* dv/header_length_frame_deframer_core_tb.sv */
`default_nettype none

module header_length_frame_deframer_core_tb;
  import hlfd_pkg::*;

  localparam int RESET_CYCLES = 8;
  localparam int WDOG_LIMIT   = 4000;
  localparam int PHASES       = 8;
  localparam int PHASE_BYTES  = 200;
  localparam int N_DIR        = 25;
  localparam int SETTLE       = 4;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [15:0] index;
    logic [31:0] length;
    logic [31:0] checksum;
  } frame_evt_t;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_op_t;
  typedef enum int {CUT_NONE, CUT_RANDOM, CUT_AT_LENGTH} frame_cut_t;

  typedef struct packed {
    row_op_t     op;
    logic [7:0]  rx;
    logic [2:0]  ridx;
    logic [31:0] val;
    logic        typed;
    logic        has;
    frame_evt_t  ev;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  hlfd_in_if  din_if ();
  hlfd_out_if dout_if ();

  header_length_frame_deframer_core dut (
    .clk     (clk),
    .rst     (rst),
    .din     (din_if),
    .dout    (dout_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4 clk = ~clk;

  // register shadow, reset values
  logic [2:0]  reg_hdr_bytes = 3'd2;
  logic [31:0] reg_hdr_value = 32'd0;
  logic [2:0]  reg_len_bytes = 3'd2;
  logic [2:0]  reg_sum_bytes = 3'd0;
  logic [16:0] reg_max_frame = 17'd256;

  // deframer state
  phase_t      st_phase  = PH_HUNT;
  logic [31:0] st_window = 32'd0;
  logic [31:0] st_len    = 32'd0;
  logic [15:0] st_cnt    = 16'd0;
  logic [31:0] st_sum    = 32'd0;

  frame_evt_t expected_frames[$];
  frame_evt_t seen_want;
  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int n_err = 0;
  int n_bytes = 0;
  int n_payload = 0;
  int n_done = 0;
  int n_reject = 0;
  int idle_cycles = 0;

  function automatic logic [2:0] bounded_count(input logic [2:0] v);
    if (v == 3'd0) return 3'd1;
    if (v > 3'd4) return 3'd4;
    return v;
  endfunction

  function automatic logic [2:0] sum_count();
    return (reg_sum_bytes > 3'd4) ? 3'd4 : reg_sum_bytes;
  endfunction

  function automatic logic [16:0] frame_limit();
    return (reg_max_frame > 17'd65536) ? 17'd65536 : reg_max_frame;
  endfunction

  // little-endian accumulate: new byte enters at the top of an n-byte field
  function automatic logic [31:0] shift_le(input logic [31:0] acc, input logic [7:0] b,
                                           input logic [2:0] n);
    int sh;
    sh = 8 * (int'(n) - 1);
    return (acc >> 8) | ({24'd0, b} << sh);
  endfunction

  function automatic bit deframe_predict(input logic [7:0] b, output frame_evt_t ev);
    logic [2:0]  n;
    logic [2:0]  sn;
    logic [31:0] mask;
    logic [33:0] tot;
    bit got;
    got = 1'b0;
    ev = '0;
    sn = sum_count();
    case (st_phase)
      PH_HUNT: begin
        n = bounded_count(reg_hdr_bytes);
        mask = (n == 3'd4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * int'(n))) - 32'd1);
        st_window = shift_le(st_window, b, n);
        if (((st_window ^ reg_hdr_value) & mask) == 32'd0) begin
          st_phase = PH_LEN;
          st_len = 32'd0;
          st_cnt = 16'd0;
        end
      end
      PH_LEN: begin
        n = bounded_count(reg_len_bytes);
        st_len = shift_le(st_len, b, n);
        st_cnt = st_cnt + 16'd1;
        if (st_cnt >= {13'd0, n}) begin
          st_cnt = 16'd0;
          tot = {2'd0, st_len} + {31'd0, sn};
          if (tot >= {17'd0, frame_limit()}) begin
            st_phase = PH_HUNT;
            got = 1'b1;
            ev.kind = KIND_REJECT;
            ev.length = st_len;
          end else if (st_len != 32'd0) begin
            st_phase = PH_DATA;
          end else if (sn != 3'd0) begin
            st_sum = 32'd0;
            st_phase = PH_CSUM;
          end else begin
            st_phase = PH_HUNT;
            got = 1'b1;
            ev.kind = KIND_DONE;
          end
        end
      end
      PH_DATA: begin
        got = 1'b1;
        ev.kind = KIND_PAYLOAD;
        ev.data = b;
        ev.index = st_cnt;
        ev.length = st_len;
        st_cnt = st_cnt + 16'd1;
        if ({16'd0, st_cnt} >= st_len) begin
          st_cnt = 16'd0;
          if (sn != 3'd0) begin
            st_sum = 32'd0;
            st_phase = PH_CSUM;
          end else begin
            st_phase = PH_HUNT;
            ev.kind = KIND_DONE;
          end
        end
      end
      default: begin
        n = (sn == 3'd0) ? 3'd1 : sn;
        st_sum = shift_le(st_sum, b, n);
        st_cnt = st_cnt + 16'd1;
        if (st_cnt >= {13'd0, n}) begin
          st_cnt = 16'd0;
          st_phase = PH_HUNT;
          got = 1'b1;
          ev.kind = KIND_DONE;
          ev.length = st_len;
          ev.checksum = st_sum;
        end
      end
    endcase
    return got;
  endfunction

  function automatic dir_row_t row_pred(input logic [7:0] b);
    dir_row_t r;
    r = '0;
    r.op = ROW_BYTE;
    r.rx = b;
    return r;
  endfunction

  function automatic dir_row_t row_none(input logic [7:0] b);
    dir_row_t r;
    r = row_pred(b);
    r.typed = 1'b1;
    return r;
  endfunction

  function automatic dir_row_t row_res(input logic [7:0] b, input kind_t k,
                                       input logic [7:0] d, input logic [15:0] idx,
                                       input logic [31:0] len, input logic [31:0] cs);
    dir_row_t r;
    r = row_none(b);
    r.has = 1'b1;
    r.ev.kind = k;
    r.ev.data = d;
    r.ev.index = idx;
    r.ev.length = len;
    r.ev.checksum = cs;
    return r;
  endfunction

  function automatic dir_row_t row_cfg(input logic [2:0] ridx, input logic [31:0] val);
    dir_row_t r;
    r = '0;
    r.op = ROW_CFG;
    r.ridx = ridx;
    r.val = val;
    return r;
  endfunction

  task automatic field_check(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      n_err++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      din_if.valid <= 1'b0;
      @(posedge clk);
    end
    din_if.valid <= 1'b1;
    din_if.rx_byte <= b;
    @(posedge clk);
    while (!din_if.ready) @(posedge clk);
    n_bytes++;
  endtask

  task automatic send_and_predict(input logic [7:0] b);
    frame_evt_t ev;
    send_byte(b);
    if (deframe_predict(b, ev)) expected_frames.push_back(ev);
  endtask

  task automatic drain_then_hold();
    din_if.valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] ridx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {ridx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (ridx)
      REG_HEADER_BYTES:   reg_hdr_bytes = val[2:0];
      REG_HEADER_VALUE:   reg_hdr_value = val;
      REG_LENGTH_BYTES:   reg_len_bytes = val[2:0];
      REG_CHECKSUM_BYTES: reg_sum_bytes = val[2:0];
      REG_MAX_FRAME:      reg_max_frame = val[16:0];
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // frame under the current settings, sometimes with a length over the limit, optionally cut short
  task automatic send_frame(input frame_cut_t cut, output int sent);
    logic [7:0]  bytes[$];
    logic [2:0]  hb, lb, cb;
    logic [16:0] lim;
    logic [31:0] len;
    logic [33:0] tot;
    int max_ok, r, stop;
    hb = bounded_count(reg_hdr_bytes);
    lb = bounded_count(reg_len_bytes);
    cb = sum_count();
    lim = frame_limit();
    max_ok = int'(lim) - int'(cb) - 1;
    for (int i = 0; i < hb; i++) bytes.push_back(reg_hdr_value[8*i +: 8]);
    r = $urandom_range(0, 99);
    if (r < 65) len = $urandom_range(0, 8);
    else if (r < 80 && max_ok >= 0 && max_ok <= 300) len = max_ok;
    else if (r < 90 && max_ok >= -1 && max_ok <= 299) len = max_ok + 1;
    else len = $urandom;
    if (lb != 3'd4) len = len & ((32'd1 << (8 * int'(lb))) - 32'd1);
    tot = {2'd0, len} + {31'd0, cb};
    if (tot < {17'd0, lim} && len > 32'd300) len = len & 32'h3F;
    tot = {2'd0, len} + {31'd0, cb};
    for (int i = 0; i < lb; i++) bytes.push_back(len[8*i +: 8]);
    if (tot < {17'd0, lim}) begin
      for (int i = 0; i < int'(len); i++) bytes.push_back(8'($urandom_range(0, 255)));
      for (int i = 0; i < cb; i++) bytes.push_back(8'($urandom_range(0, 255)));
    end
    stop = bytes.size();
    if (cut == CUT_RANDOM && stop > 1) stop = $urandom_range(1, stop - 1);
    else if (cut == CUT_AT_LENGTH) stop = int'(hb) + 1;
    for (int i = 0; i < stop; i++) send_and_predict(bytes[i]);
    sent = stop;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      dout_if.ready <= 1'b0;
    end else begin
      if (dout_if.valid && dout_if.ready) begin
        if (expected_frames.size() == 0) begin
          n_err++;
          $display("%0t: unexpected result, kind %0d length 0x%0h", $time, dout_if.kind,
                   dout_if.frame_length);
        end else begin
          seen_want = expected_frames.pop_front();
          field_check("kind", 32'(seen_want.kind), 32'(dout_if.kind));
          field_check("payload_byte", 32'(seen_want.data), 32'(dout_if.payload_byte));
          field_check("byte_index", 32'(seen_want.index), 32'(dout_if.byte_index));
          field_check("frame_length", seen_want.length, dout_if.frame_length);
          field_check("received_checksum", seen_want.checksum, dout_if.received_checksum);
          case (seen_want.kind)
            KIND_PAYLOAD: n_payload++;
            KIND_DONE:    n_done++;
            default:      n_reject++;
          endcase
        end
      end
      dout_if.ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready) ||
          (psel && penable)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("%0t: watchdog, no transfer for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, expected_frames.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t    dir_tab [N_DIR];
    frame_evt_t  ev;
    bit          got;
    logic [2:0]  hb, lb, cb;
    logic [31:0] hv;
    logic [16:0] mf;
    int quota, sent, r;

    din_if.valid = 1'b0;
    din_if.rx_byte = 8'd0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = 32'd0;

    // reset settings: 2-byte header of zeros, 2-byte length, no checksum, limit 256
    dir_tab = '{
      row_none(8'h00),
      row_none(8'h03), row_none(8'h00),
      row_pred(8'hAA), row_pred(8'h55),
      row_res(8'hFF, KIND_DONE, 8'hFF, 16'd2, 32'd3, 32'd0),
      row_none(8'h00),
      row_pred(8'h00),
      row_res(8'h00, KIND_DONE, 8'h00, 16'd0, 32'd0, 32'd0),
      row_none(8'hFF), row_none(8'h80), row_none(8'h00), row_none(8'h00),
      row_pred(8'h01), row_pred(8'h00),
      row_res(8'h7F, KIND_DONE, 8'h7F, 16'd0, 32'd1, 32'd0),
      row_none(8'h00),
      row_none(8'hFF),
      row_res(8'hFF, KIND_REJECT, 8'h00, 16'd0, 32'h0000_FFFF, 32'd0),
      row_cfg(REG_CHECKSUM_BYTES, 32'd2),
      row_none(8'h00),
      row_pred(8'h00), row_none(8'h00),
      row_pred(8'h34),
      row_res(8'h12, KIND_DONE, 8'h00, 16'd0, 32'd0, 32'h0000_1234)
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIR; i++) begin
      if (dir_tab[i].op == ROW_CFG) begin
        drain_then_hold();
        cfg_write(dir_tab[i].ridx, dir_tab[i].val);
      end else begin
        send_byte(dir_tab[i].rx);
        got = deframe_predict(dir_tab[i].rx, ev);
        if (dir_tab[i].typed) begin
          if (dir_tab[i].has) expected_frames.push_back(dir_tab[i].ev);
        end else if (got) begin
          expected_frames.push_back(ev);
        end
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain_then_hold();
      hv = $urandom;
      case (p)
        0: begin hb = 3'd2; lb = 3'd2; cb = 3'd0; mf = 17'd256; end
        1: begin hb = 3'd1; lb = 3'd1; cb = 3'd1; mf = 17'($urandom_range(20, 300)); end
        2: begin hb = 3'd4; lb = 3'd4; cb = 3'd4; mf = 17'd65536; hv = 32'hFFFF_FFFF; end
        3: begin hb = 3'd3; lb = 3'd3; cb = 3'd3; mf = 17'd0; end
        4: begin hb = 3'd0; lb = 3'd5; cb = 3'd6; mf = 17'h1_FFFF; end
        5: begin
          hb = 3'd7; lb = 3'd0; cb = 3'd2; mf = 17'($urandom_range(8, 64)); hv = 32'd0;
        end
        default: begin
          hb = 3'($urandom_range(1, 4));
          lb = 3'($urandom_range(1, 4));
          cb = 3'($urandom_range(0, 4));
          mf = 17'($urandom_range(16, 400));
        end
      endcase
      case (p % 4)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 53; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 53; end
        default: begin snd_idle_pct = 22; rcv_stall_pct = 22; end
      endcase
      cfg_write(REG_HEADER_BYTES, {29'd0, hb});
      cfg_write(REG_HEADER_VALUE, hv);
      cfg_write(REG_LENGTH_BYTES, {29'd0, lb});
      cfg_write(REG_CHECKSUM_BYTES, {29'd0, cb});
      cfg_write(REG_MAX_FRAME, {15'd0, mf});
      quota = 0;
      while (quota < PHASE_BYTES) begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          repeat ($urandom_range(1, 6)) send_and_predict(8'($urandom_range(0, 255)));
        end else begin
          send_frame((r < 20) ? CUT_RANDOM : CUT_NONE, sent);
          quota += sent;
        end
      end
      // cut a frame after its first length byte so the next settings land mid-length when the length field is wider
      send_frame(CUT_AT_LENGTH, sent);
    end

    drain_then_hold();
    $display("sent %0d bytes over %0d register settings and four idle/stall mixes", n_bytes,
             PHASES + 2);
    $display("checked %0d payload bytes, %0d completed frames, %0d rejected lengths",
             n_payload, n_done, n_reject);
    if (n_err == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", n_err);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
